FILE: sv/tccs_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Shared commands, character constants, sequencer states and the control
// bundle that drives the cell sweep counter.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Console commands carried in the cmd field of a request.
  typedef enum logic [1:0] {
    CMD_PUT       = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_BACKSPACE = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  // Character and attribute constants.
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EXEC  = 7'b0000010,
    ST_COPY  = 7'b0000100,
    ST_FLUSH = 7'b0001000,
    ST_BLANK = 7'b0010000,
    ST_CLEAR = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  // Control bundle for the sweep counter.
  typedef struct packed {
    logic load;
    logic step;
  } sweep_ctrl_t;

endpackage

FILE: sv/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Character-cell screen of ROWS x COLUMNS 16-bit cells, driven by put,
// clear, backspace and read commands, one result per request.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid_i / in_stall_o  | cmd_i, char_code_i, cell_index_i
//  out      | out_valid_o / out_stall_i| cursor_row_o, cursor_col_o,
//           |                        | cell_value_o, scrolled_o
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_text_attribute_i
//
// A put, backspace, newline or read request that does not scroll passes
// through accept, execute and respond. A scroll walks the cell memory once
// through its single read and single write port. Clear writes every cell.
// Only one request is in flight; a new request is taken while the previous
// result still waits on out_stall_i.
// Reset homes the cursor and loads the attribute with 0x0F; cell contents
// are undefined until written.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic [15:0] cell_value_o,
  output logic        scrolled_o,
  // Attribute register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_text_attribute_i
);

  localparam int Cells     = ROWS * COLUMNS;
  localparam int AW        = $clog2(Cells);
  localparam int RowW      = $clog2(ROWS);
  localparam int ColW      = $clog2(COLUMNS);
  localparam int LastRowBase = (ROWS - 1) * COLUMNS;

  tccs_pkg::state_e state_q, state_d;

  logic [7:0]      attr_q;
  tccs_pkg::cmd_e  cmd_q;
  logic [7:0]      ch_q;
  logic [10:0]     idx_q;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [AW-1:0]   lin_q, lin_d;
  logic            scrolled_q, scrolled_d;
  logic            copy_pend_q, copy_pend_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;

  logic            out_valid_q;
  logic [4:0]      out_row_q;
  logic [6:0]      out_col_q;
  logic [15:0]     out_value_q;
  logic            out_scrolled_q;

  logic            in_accept;
  logic            resp_fire;

  // Memory and sweep connections
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [15:0]     mem_rdata;

  tccs_pkg::sweep_ctrl_t sweep_ctrl;
  logic [AW-1:0]   sweep_first;
  logic [AW-1:0]   sweep_last;
  logic [AW-1:0]   sweep_ptr;
  logic            sweep_at_end;

  // Command decode
  logic            is_newline;
  logic            is_putch;
  logic            col_last;
  logic            row_last;
  logic            do_scroll;
  logic            at_home;
  logic [AW-1:0]   bs_lin;
  logic [15:0]     blank_cell;
  logic [31:0]     idx_ext;
  logic            idx_ok;
  logic [AW-1:0]   idx_addr;
  logic [31:0]     row_ext;
  logic [31:0]     col_ext;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != tccs_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign is_newline = (cmd_q == tccs_pkg::CMD_PUT) && (ch_q == tccs_pkg::NEWLINE_CHAR);
  assign is_putch   = (cmd_q == tccs_pkg::CMD_PUT) && (ch_q != tccs_pkg::NEWLINE_CHAR);
  assign col_last   = (col_q == ColW'(COLUMNS - 1));
  assign row_last   = (row_q == RowW'(ROWS - 1));
  assign do_scroll  = row_last && (is_newline || (is_putch && col_last));
  assign at_home    = (row_q == '0) && (col_q == '0);
  assign bs_lin     = at_home ? lin_q : lin_q - AW'(1);
  assign blank_cell = {attr_q, tccs_pkg::BLANK_CHAR};

  assign idx_ext  = 32'(idx_q);
  assign idx_ok   = (idx_ext < 32'(Cells));
  assign idx_addr = idx_ok ? idx_ext[AW-1:0] : '0;

  assign resp_fire = (state_q == tccs_pkg::ST_RESP) && (!out_valid_q || !out_stall_i);

  // Attribute register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccs_pkg::ATTR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      attr_q <= cfg_text_attribute_i;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= tccs_pkg::cmd_e'(cmd_i);
      ch_q  <= char_code_i;
      idx_q <= cell_index_i;
    end
  end

  // Sequencer: cursor update, memory port and sweep control.
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    lin_d       = lin_q;
    scrolled_d  = scrolled_q;
    copy_pend_d = copy_pend_q;
    wr_addr_d   = wr_addr_q;
    mem_we      = 1'b0;
    mem_waddr   = lin_q;
    mem_wdata   = blank_cell;
    mem_re      = 1'b0;
    mem_raddr   = sweep_ptr;
    sweep_ctrl  = '0;
    sweep_first = '0;
    sweep_last  = AW'(Cells - 1);

    case (state_q)
      tccs_pkg::ST_IDLE: begin
        if (in_accept) begin
          scrolled_d = 1'b0;
          state_d    = tccs_pkg::ST_EXEC;
        end
      end

      tccs_pkg::ST_EXEC: begin
        state_d = tccs_pkg::ST_RESP;
        case (cmd_q)
          tccs_pkg::CMD_PUT: begin
            if (is_putch) begin
              mem_we    = 1'b1;
              mem_waddr = lin_q;
              mem_wdata = {attr_q, ch_q};
            end
            if (do_scroll) begin
              row_d       = RowW'(ROWS - 1);
              col_d       = '0;
              lin_d       = AW'(LastRowBase);
              scrolled_d  = 1'b1;
              copy_pend_d = 1'b0;
              sweep_ctrl.load = 1'b1;
              sweep_first = AW'(COLUMNS);
              state_d     = tccs_pkg::ST_COPY;
            end else if (is_newline) begin
              row_d = row_q + RowW'(1);
              col_d = '0;
              lin_d = lin_q - AW'(col_q) + AW'(COLUMNS);
            end else begin
              lin_d = lin_q + AW'(1);
              if (col_last) begin
                row_d = row_q + RowW'(1);
                col_d = '0;
              end else begin
                col_d = col_q + ColW'(1);
              end
            end
          end
          tccs_pkg::CMD_CLEAR: begin
            row_d = '0;
            col_d = '0;
            lin_d = '0;
            sweep_ctrl.load = 1'b1;
            state_d = tccs_pkg::ST_CLEAR;
          end
          tccs_pkg::CMD_BACKSPACE: begin
            if (col_q != '0) begin
              col_d = col_q - ColW'(1);
            end else if (row_q != '0) begin
              row_d = row_q - RowW'(1);
              col_d = ColW'(COLUMNS - 1);
            end
            lin_d     = bs_lin;
            mem_we    = 1'b1;
            mem_waddr = bs_lin;
          end
          default: begin
            mem_re    = 1'b1;
            mem_raddr = idx_addr;
          end
        endcase
      end

      // Move each row up: read one cell per cycle and write it in the following cycle.
      tccs_pkg::ST_COPY: begin
        mem_re          = 1'b1;
        mem_raddr       = sweep_ptr;
        mem_we          = copy_pend_q;
        mem_waddr       = wr_addr_q;
        mem_wdata       = mem_rdata;
        wr_addr_d       = sweep_ptr - AW'(COLUMNS);
        copy_pend_d     = 1'b1;
        sweep_ctrl.step = 1'b1;
        if (sweep_at_end) begin
          state_d = tccs_pkg::ST_FLUSH;
        end
      end

      // Write the last copied cell and start blanking the bottom row.
      tccs_pkg::ST_FLUSH: begin
        mem_we          = 1'b1;
        mem_waddr       = wr_addr_q;
        mem_wdata       = mem_rdata;
        copy_pend_d     = 1'b0;
        sweep_ctrl.load = 1'b1;
        sweep_first     = AW'(LastRowBase);
        state_d         = tccs_pkg::ST_BLANK;
      end

      tccs_pkg::ST_BLANK, tccs_pkg::ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = sweep_ptr;
        sweep_ctrl.step = 1'b1;
        if (sweep_at_end) begin
          state_d = tccs_pkg::ST_RESP;
        end
      end

      tccs_pkg::ST_RESP: begin
        if (resp_fire) begin
          state_d = tccs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccs_pkg::ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      lin_q       <= '0;
      scrolled_q  <= 1'b0;
      copy_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      lin_q       <= lin_d;
      scrolled_q  <= scrolled_d;
      copy_pend_q <= copy_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
  end

  // Result register.
  assign row_ext = 32'(row_q);
  assign col_ext = 32'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_fire) begin
      out_row_q      <= row_ext[4:0];
      out_col_q      <= col_ext[6:0];
      out_value_q    <= ((cmd_q == tccs_pkg::CMD_READ) && idx_ok) ? mem_rdata : 16'h0000;
      out_scrolled_q <= scrolled_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_value_o = out_value_q;
  assign scrolled_o   = out_scrolled_q;

  // Cell memory.
  tccs_ram #(
    .Depth (Cells),
    .Width (16)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Address walker for copy, blank and clear.
  tccs_sweep #(
    .Depth (Cells)
  ) u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sweep_ctrl),
    .first_i  (sweep_first),
    .last_i   (sweep_last),
    .ptr_o    (sweep_ptr),
    .at_end_o (sweep_at_end)
  );

  // The cursor always stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < 32'(ROWS)) && (32'(col_q) < 32'(COLUMNS)))
    else $error("cursor left the screen");

  // The linear cursor address tracks row and column between requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccs_pkg::ST_IDLE) |->
      (32'(lin_q) == 32'(row_q) * 32'(COLUMNS) + 32'(col_q)))
    else $error("linear cursor address out of step with row and column");

  // A scroll leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tccs_pkg::ST_RESP) && scrolled_q) |->
      ((row_q == RowW'(ROWS - 1)) && (col_q == '0)))
    else $error("scroll did not home the cursor to the bottom row");

  // The final copy write only follows the copy sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccs_pkg::ST_FLUSH) |-> ($past(state_q) == tccs_pkg::ST_COPY))
    else $error("flush entered outside a scroll copy");

  // An accepted request starts execution; requests are taken only while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == tccs_pkg::ST_EXEC))
    else $error("accepted request did not start execution");

endmodule

FILE: sv/tccs_ram.sv
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int Depth = 2000,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tccs_sweep.sv
// ----------------------------------------------------------------------------
// Cell sweep counter
// Shared address walker used by scroll copy, row blanking and screen clear.
// It is loaded with a first and a last address and steps by one per cycle while step is set.
// ----------------------------------------------------------------------------
module tccs_sweep #(
  parameter int Depth = 2000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tccs_pkg::sweep_ctrl_t       ctrl_i,
  input  logic [$clog2(Depth)-1:0]    first_i,
  input  logic [$clog2(Depth)-1:0]    last_i,
  output logic [$clog2(Depth)-1:0]    ptr_o,
  output logic                        at_end_o
);

  localparam int AW = $clog2(Depth);

  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] end_q, end_d;

  // Next pointer: load, step or hold.
  always_comb begin
    ptr_d = ptr_q;
    end_d = end_q;
    if (ctrl_i.load) begin
      ptr_d = first_i;
      end_d = last_i;
    end else if (ctrl_i.step) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      end_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      end_q <= end_d;
    end
  end

  assign ptr_o    = ptr_q;
  assign at_end_o = (ptr_q == end_q);

endmodule
